// ----- rtl/core/bli_pkg.sv -----
// ---------------------------------------------------------------------------
// bli_pkg
// Shared types, constants and helper functions of the battery LED indicator.
// ---------------------------------------------------------------------------
package bli_pkg;

  localparam int unsigned PWM_LEVELS  = 32;
  localparam int unsigned HOLD_STEPS  = 8;
  localparam int unsigned GAP_STEPS   = 16;
  localparam int unsigned PHASE_STEPS = PWM_LEVELS + HOLD_STEPS;
  localparam int unsigned TOTAL_1     = 1 * PHASE_STEPS + GAP_STEPS;
  localparam int unsigned TOTAL_2     = 2 * PHASE_STEPS + GAP_STEPS;
  localparam int unsigned TOTAL_3     = 3 * PHASE_STEPS + GAP_STEPS;
  localparam int unsigned RES_W       = $clog2(TOTAL_3);
  localparam int unsigned PWM_W       = $clog2(PWM_LEVELS);
  localparam int unsigned WAVE_W      = 32;

  localparam int unsigned DUR_W       = 10;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned BLINK_W     = 7;
  localparam int unsigned BLINK_WRAP  = 120;
  localparam int unsigned ELAPSED_MAX = 1023;

  localparam logic [DUR_W-1:0] DUR_RST  = DUR_W'(500);
  localparam logic [PCT_W-1:0] FULL_RST = PCT_W'(95);
  localparam logic [PCT_W-1:0] LOW_RST  = PCT_W'(33);
  localparam logic [PCT_W-1:0] MID_RST  = PCT_W'(66);

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_DURATION = 2'd0,
    REG_FULL     = 2'd1,
    REG_LOW      = 2'd2,
    REG_MID      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SHORT = 2'd1,
    CMD_LONG  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_LEVEL  = 3'd1,
    MODE_BLINK  = 3'd2,
    MODE_CHARGE = 3'd3,
    MODE_TEST   = 3'd4
  } mode_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [PCT_W-1:0] bat_pct;
    logic             usb_in;
    logic             test_mode;
  } bli_in_t;

  typedef struct packed {
    logic       led1_on;
    logic       led2_on;
    logic       led3_on;
    logic [2:0] display_mode;
  } bli_out_t;

  typedef struct packed {
    logic [DUR_W-1:0] temp_duration_ticks;
    logic [PCT_W-1:0] full_pct;
    logic [PCT_W-1:0] low_pct;
    logic [PCT_W-1:0] mid_pct;
  } bli_cfg_t;

  // LED count for a level: 1, 2 or 3
  function automatic logic [1:0] level_leds(input logic [PCT_W-1:0] pct,
                                            input logic [PCT_W-1:0] low,
                                            input logic [PCT_W-1:0] mid);
    logic [1:0] n;
    if (pct <= low) begin
      n = 2'd1;
    end else if (pct <= mid) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [RES_W-1:0] chase_total(input logic [1:0] n);
    logic [RES_W-1:0] t;
    case (n)
      2'd1:    t = RES_W'(TOTAL_1);
      2'd2:    t = RES_W'(TOTAL_2);
      default: t = RES_W'(TOTAL_3);
    endcase
    return t;
  endfunction

  // blink_count mod 40 below 20
  function automatic logic blink_on(input logic [BLINK_W-1:0] b);
    return (b < BLINK_W'(20)) ||
           (b >= BLINK_W'(40) && b < BLINK_W'(60)) ||
           (b >= BLINK_W'(80) && b < BLINK_W'(100));
  endfunction

endpackage

// ----- rtl/core/bli_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// bli_cfg_regs
// APB register file for display duration and level thresholds.
// ---------------------------------------------------------------------------
module bli_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bli_pkg::ADDR_W-1:0]  paddr,
  input  logic [bli_pkg::DATA_W-1:0]  pwdata,
  output logic [bli_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bli_pkg::bli_cfg_t           cfg_o
);
  import bli_pkg::*;

  bli_cfg_t cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DURATION: cfg_d.temp_duration_ticks = pwdata[DUR_W-1:0];
        REG_FULL:     cfg_d.full_pct            = pwdata[PCT_W-1:0];
        REG_LOW:      cfg_d.low_pct             = pwdata[PCT_W-1:0];
        REG_MID:      cfg_d.mid_pct             = pwdata[PCT_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DURATION: prdata = DATA_W'(cfg_q.temp_duration_ticks);
      REG_FULL:     prdata = DATA_W'(cfg_q.full_pct);
      REG_LOW:      prdata = DATA_W'(cfg_q.low_pct);
      REG_MID:      prdata = DATA_W'(cfg_q.mid_pct);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_duration_ticks <= DUR_RST;
      cfg_q.full_pct            <= FULL_RST;
      cfg_q.low_pct             <= LOW_RST;
      cfg_q.mid_pct             <= MID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/core/bli_core.sv -----
// ---------------------------------------------------------------------------
// bli_core
// Tick state (press display, blink, breathing chase) and next LED word.
// ---------------------------------------------------------------------------
module bli_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  bli_pkg::bli_in_t  in_i,
  input  bli_pkg::bli_cfg_t cfg_i,
  output bli_pkg::bli_out_t res_o
);
  import bli_pkg::*;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_e;

  kind_e              kind_q, kind_d, kind_a, kind_b;
  logic [DUR_W-1:0]   elapsed_q, elapsed_d, elapsed_a, elapsed_b;
  logic [BLINK_W-1:0] blink_q, blink_d, blink_inc, test_t;
  logic [WAVE_W-1:0]  wave_q, wave_d;
  logic [PWM_W-1:0]   pwm_q, pwm_d;
  logic [RES_W-1:0]   res_q [3];
  logic [RES_W-1:0]   res_d [3];
  logic [RES_W-1:0]   res_inc [3];
  logic [RES_W-1:0]   step;
  logic [PWM_W-1:0]   bright [3];
  logic [2:0]         lit_chase;
  logic [1:0]         n_lvl;
  logic               in_chase;
  logic               wave_wrap;
  logic               pwm_wrap;
  bli_out_t           res;

  assign n_lvl     = level_leds(in_i.bat_pct, cfg_i.low_pct, cfg_i.mid_pct);
  assign blink_inc = (blink_q == BLINK_W'(BLINK_WRAP - 1)) ? '0 : blink_q + 1'b1;
  assign test_t    = (blink_inc >= BLINK_W'(60)) ? blink_inc - BLINK_W'(60) : blink_inc;
  assign wave_wrap = &wave_q;
  assign pwm_wrap  = (pwm_q == PWM_W'(PWM_LEVELS - 1));
  assign step      = res_q[n_lvl - 2'd1];
  assign in_chase  = step < RES_W'(32'(n_lvl) * PHASE_STEPS);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (wave_wrap || res_q[k] == chase_total(2'(k + 1)) - 1'b1) begin
        res_inc[k] = '0;
      end else begin
        res_inc[k] = res_q[k] + 1'b1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (!in_chase || step < RES_W'(j * PHASE_STEPS)) begin
        bright[j] = '0;
      end else if (step >= RES_W'(j * PHASE_STEPS + PWM_LEVELS - 1)) begin
        bright[j] = PWM_W'(PWM_LEVELS - 1);
      end else begin
        bright[j] = PWM_W'(step - RES_W'(j * PHASE_STEPS));
      end
      lit_chase[j] = (bright[j] == PWM_W'(PWM_LEVELS - 1)) ||
                     (bright[j] != '0 && pwm_q < bright[j]);
    end
  end

  always_comb begin
    kind_a    = kind_q;
    elapsed_a = elapsed_q;
    case (cmd_e'(in_i.command))
      CMD_SHORT: begin
        kind_a    = KIND_SHORT;
        elapsed_a = '0;
      end
      CMD_LONG: begin
        kind_a    = KIND_LONG;
        elapsed_a = '0;
      end
      default: ;
    endcase
    kind_b    = kind_a;
    elapsed_b = elapsed_a;
    if (kind_a != KIND_NONE && elapsed_a >= cfg_i.temp_duration_ticks) begin
      kind_b    = KIND_NONE;
      elapsed_b = '0;
    end

    blink_d = blink_q;
    wave_d  = wave_q;
    pwm_d   = pwm_q;
    res_d   = res_q;
    res     = '0;
    res.display_mode = MODE_OFF;

    case (kind_b)
      KIND_SHORT: begin
        res.led1_on      = (in_i.bat_pct != '0);
        res.led2_on      = (in_i.bat_pct != '0) && (n_lvl >= 2'd2);
        res.led3_on      = (in_i.bat_pct != '0) && (n_lvl == 2'd3);
        res.display_mode = MODE_LEVEL;
        blink_d = '0;
        wave_d  = '0;
        pwm_d   = '0;
        res_d   = '{default: '0};
      end
      KIND_LONG: begin
        blink_d          = blink_inc;
        res.led1_on      = blink_on(blink_inc);
        res.led2_on      = blink_on(blink_inc);
        res.led3_on      = blink_on(blink_inc);
        res.display_mode = MODE_BLINK;
        wave_d = '0;
        pwm_d  = '0;
        res_d  = '{default: '0};
      end
      default: begin
        if (in_i.usb_in) begin
          blink_d          = '0;
          res.display_mode = MODE_CHARGE;
          if (in_i.bat_pct >= cfg_i.full_pct) begin
            res.led1_on = 1'b1;
            res.led2_on = 1'b1;
            res.led3_on = 1'b1;
            wave_d = '0;
            pwm_d  = '0;
            res_d  = '{default: '0};
          end else begin
            res.led1_on = lit_chase[0];
            res.led2_on = lit_chase[1];
            res.led3_on = lit_chase[2];
            pwm_d = pwm_wrap ? '0 : pwm_q + 1'b1;
            if (pwm_wrap) begin
              wave_d = wave_q + 1'b1;
              res_d  = res_inc;
            end
          end
        end else if (in_i.test_mode) begin
          blink_d          = blink_inc;
          res.led1_on      = test_t < BLINK_W'(20);
          res.led2_on      = test_t >= BLINK_W'(20) && test_t < BLINK_W'(40);
          res.led3_on      = test_t >= BLINK_W'(40);
          res.display_mode = MODE_TEST;
          wave_d = '0;
          pwm_d  = '0;
          res_d  = '{default: '0};
        end else begin
          blink_d = '0;
          wave_d  = '0;
          pwm_d   = '0;
          res_d   = '{default: '0};
        end
      end
    endcase

    kind_d    = kind_b;
    elapsed_d = elapsed_b;
    if (kind_b != KIND_NONE && elapsed_b < DUR_W'(ELAPSED_MAX)) begin
      elapsed_d = elapsed_b + 1'b1;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= KIND_NONE;
      elapsed_q <= '0;
      blink_q   <= '0;
      wave_q    <= '0;
      pwm_q     <= '0;
      res_q     <= '{default: '0};
    end else if (accept_i) begin
      kind_q    <= kind_d;
      elapsed_q <= elapsed_d;
      blink_q   <= blink_d;
      wave_q    <= wave_d;
      pwm_q     <= pwm_d;
      res_q     <= res_d;
    end
  end

  a_blink_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blink_q < BLINK_W'(BLINK_WRAP))
    else $error("blink counter out of range");

  a_idle_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == KIND_NONE |-> elapsed_q == '0)
    else $error("elapsed count kept without a press display");

  a_res_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q[0] < RES_W'(TOTAL_1) && res_q[1] < RES_W'(TOTAL_2) &&
    res_q[2] < RES_W'(TOTAL_3))
    else $error("chase residue out of range");

  a_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wave_q == '0 |-> res_q[0] == '0 && res_q[1] == '0 && res_q[2] == '0)
    else $error("chase residue not in step with wave counter");

endmodule

// ----- rtl/core/bli_out_reg.sv -----
// ---------------------------------------------------------------------------
// bli_out_reg
// Result register with valid/stall handshake toward the consumer.
// ---------------------------------------------------------------------------
module bli_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bli_pkg::bli_out_t data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output bli_pkg::bli_out_t out_data_o,
  output logic              busy_o
);
  import bli_pkg::*;

  logic     valid_q, valid_d;
  bli_out_t data_q;

  assign busy_o      = valid_q & out_stall_i;
  assign valid_d     = load_i | busy_o;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- rtl/core/battery_led_indicator.sv -----
// ---------------------------------------------------------------------------
// battery_led_indicator
// Per-tick three-LED battery indicator with press displays and charge chase.
// ---------------------------------------------------------------------------
// The result word is registered and shown on the output in the cycle after its tick word is accepted.
// Throughput: one word per cycle while the output is not stalled; the result register is the only stage.
// A new word is taken while the previous result is consumed in the same cycle.
// Reset: registers return to defaults, all tick state clears, output empty.
module battery_led_indicator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bli_pkg::bli_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bli_pkg::bli_out_t           out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bli_pkg::ADDR_W-1:0]  paddr,
  input  logic [bli_pkg::DATA_W-1:0]  pwdata,
  output logic [bli_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bli_pkg::*;

  bli_cfg_t cfg;
  bli_out_t res;
  logic     accept;
  logic     busy;

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  bli_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bli_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  bli_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .data_i      (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .busy_o      (busy)
  );

endmodule
